### rtl/rfpd_pkg.sv
// Package for the region-of-interest foreground presence detector.
// Holds the transaction payload types, register indexes, widths and thresholds.
// No dependencies.
package rfpd_pkg;

	// Largest frame side that the position counters cover.
	localparam int MAX_SIDE = 4096;
	localparam int POS_W    = $clog2(MAX_SIDE);
	localparam int EFF_W    = POS_W + 1;

	// Register field widths.
	localparam int SIDE_W   = 13;
	localparam int EDGE_W   = 12;
	localparam int CFG_IX_W = 3;

	// Count and compare widths.
	localparam int CNT_W    = 25;
	localparam int AREA_W   = 2 * SIDE_W;
	localparam int SCALED_W = CNT_W + 4;
	localparam int RUN_W    = 8;
	localparam int WARM_W   = 5;

	localparam logic [7:0]        PIX_THRESHOLD = 8'd10;
	localparam logic [RUN_W-1:0]  FOUND_RUN     = 8'd10;
	localparam logic [RUN_W-1:0]  RUN_MAX       = 8'd255;
	localparam logic [WARM_W-1:0] WARMUP_LEN    = 5'd16;
	localparam logic [CNT_W-1:0]  CNT_MAX       = {CNT_W{1'b1}};

	typedef enum logic [CFG_IX_W-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_BOX_LEFT     = 3'd2,
		REG_BOX_TOP      = 3'd3,
		REG_BOX_WIDTH    = 3'd4,
		REG_BOX_HEIGHT   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       frame_start;
	} pix_t;

	typedef struct packed {
		logic             hand_found;
		logic             region_active;
		logic [RUN_W-1:0] run_length;
		logic             warming_up;
		logic [CNT_W-1:0] foreground_count;
	} res_t;

	// A frame side of zero acts as one; a side above MAX_SIDE acts as MAX_SIDE.
	function automatic logic [EFF_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
		logic [EFF_W-1:0] r;
		if (v == '0) begin
			r = EFF_W'(1);
		end else if (32'(v) > MAX_SIDE) begin
			r = EFF_W'(MAX_SIDE);
		end else begin
			r = EFF_W'(v);
		end
		return r;
	endfunction

endpackage

### rtl/roi_foreground_presence_detector_top.sv
// Top level of the region-of-interest foreground presence detector.
// Depends on rfpd_pkg for payload types, register indexes and constants.
//
//  Channel | Direction | Signals                               | Payload
//  --------+-----------+---------------------------------------+------------------------
//  pix     | in        | pix_valid, pix_ready, pix             | one mask pixel
//  res     | out       | res_valid, res_ready, res             | one result per frame
//  cfg     | in        | cfg_valid, cfg_ready, cfg_index/data  | one register write
//
// Cycles: one pixel transaction is taken every clock cycle while the result side keeps up.
// A pixel moves through the input register, the count stage and the result register, and the
// result of a frame leaves the result register once its last pixel has passed through them.
// Reset clears the position, tally, warm-up and run state and loads the register defaults.
// A stalled result holds the result register; new pixels keep flowing until a second finished
// frame waits behind it, and only then does pix_ready drop. The cfg channel is always ready.
module roi_foreground_presence_detector_top
	import rfpd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	output logic                pix_ready,
	input  pix_t                pix,
	output logic                res_valid,
	input  logic                res_ready,
	output res_t                res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_IX_W-1:0] cfg_index,
	input  logic [SIDE_W-1:0]   cfg_data
);

	// Configuration registers.
	logic [SIDE_W-1:0] frame_width_q, frame_height_q, box_width_q, box_height_q;
	logic [EDGE_W-1:0] box_left_q, box_top_q;
	logic [AREA_W-1:0] area_q;

	// Input register.
	logic       valid_s1;
	pix_t       pix_s1;

	// Count stage register: holds the finished tally of a frame.
	logic             valid_s2;
	logic [CNT_W-1:0] count_s2;

	// Frame scan state.
	logic [POS_W-1:0] col_q, line_q;
	logic [CNT_W-1:0] tally_q;

	// Run state.
	logic [WARM_W-1:0] warmup_q;
	logic              prev_active_q;
	logic [RUN_W-1:0]  run_q;

	// Result register.
	logic res_valid_q;
	res_t res_q;

	// Handshake flow: each stage frees when the one after it can take its contents.
	logic res_free, s2_free, s1_go, s2_go;

	assign res_free  = !res_valid_q || res_ready;
	assign s2_free   = !valid_s2 || res_free;
	assign s2_go     = valid_s2 && res_free;
	assign s1_go     = valid_s1 && s2_free;
	assign pix_ready = !valid_s1 || s2_free;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Register writes. An index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= SIDE_W'(640);
			frame_height_q <= SIDE_W'(480);
			box_left_q     <= '0;
			box_top_q      <= '0;
			box_width_q    <= SIDE_W'(64);
			box_height_q   <= SIDE_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				REG_BOX_LEFT:     box_left_q     <= cfg_data[EDGE_W-1:0];
				REG_BOX_TOP:      box_top_q      <= cfg_data[EDGE_W-1:0];
				REG_BOX_WIDTH:    box_width_q    <= cfg_data;
				REG_BOX_HEIGHT:   box_height_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// The box area is only needed at the end of a frame, in the frame stage,
	// so it is computed once per cycle from the registers into its own register.
	always_ff @(posedge clk) begin
		area_q <= AREA_W'(box_width_q) * AREA_W'(box_height_q);
	end

	// ---------------------------------------------------------------------
	// Count stage: position tracking, box test and tally.
	// ---------------------------------------------------------------------
	logic [EFF_W-1:0] fw_eff, fh_eff;
	logic [POS_W-1:0] col0, line0, col_c, line_c;
	logic [CNT_W-1:0] tally0, tally_n;
	logic             col_last, line_last, frame_last, in_box, hit;

	always_comb begin
		fw_eff = eff_side(frame_width_q);
		fh_eff = eff_side(frame_height_q);

		// A frame start drops any partial frame and restarts at the top left corner.
		col0   = pix_s1.frame_start ? '0 : col_q;
		line0  = pix_s1.frame_start ? '0 : line_q;
		tally0 = pix_s1.frame_start ? '0 : tally_q;

		// A frame that shrank under the current position clamps it to the last place.
		col_c  = (EFF_W'(col0) >= fw_eff)  ? POS_W'(fw_eff - EFF_W'(1)) : col0;
		line_c = (EFF_W'(line0) >= fh_eff) ? POS_W'(fh_eff - EFF_W'(1)) : line0;

		in_box = (32'(col_c) >= 32'(box_left_q))
			&& (32'(col_c) < 32'(box_left_q) + 32'(box_width_q))
			&& (32'(line_c) >= 32'(box_top_q))
			&& (32'(line_c) < 32'(box_top_q) + 32'(box_height_q));
		hit = (pix_s1.pixel > PIX_THRESHOLD) && in_box;

		tally_n = (hit && tally0 != CNT_MAX) ? tally0 + CNT_W'(1) : tally0;

		col_last   = (EFF_W'(col_c) == fw_eff - EFF_W'(1));
		line_last  = (EFF_W'(line_c) == fh_eff - EFF_W'(1));
		frame_last = col_last && line_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			col_q    <= '0;
			line_q   <= '0;
			tally_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (pix_ready) begin
				valid_s1 <= pix_valid;
			end
			if (s1_go) begin
				if (col_last) begin
					col_q  <= '0;
					line_q <= line_last ? '0 : line_c + POS_W'(1);
				end else begin
					col_q  <= col_c + POS_W'(1);
					line_q <= line_c;
				end
				tally_q <= frame_last ? '0 : tally_n;
			end
			if (s2_free) begin
				valid_s2 <= s1_go && frame_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && pix_ready) begin
			pix_s1 <= pix;
		end
		if (s2_free) begin
			count_s2 <= tally_n;
		end
	end

	// ---------------------------------------------------------------------
	// Frame stage: fill test, warm-up and run counter.
	// ---------------------------------------------------------------------
	logic [SCALED_W-1:0] scaled;
	logic                active, warm, prev_n;
	logic [RUN_W-1:0]    run_n;
	logic [WARM_W-1:0]   warmup_n;

	always_comb begin
		// Ten times the count, as 8x + 2x.
		scaled = {1'b0, count_s2, 3'b000} + {3'b000, count_s2, 1'b0};
		active = scaled > SCALED_W'(area_q);
		warm   = warmup_q < WARMUP_LEN;

		warmup_n = warmup_q;
		prev_n   = prev_active_q;
		run_n    = run_q;
		if (warm) begin
			warmup_n = warmup_q + WARM_W'(1);
		end else if (active) begin
			if (prev_active_q && run_q != RUN_MAX) begin
				run_n = run_q + RUN_W'(1);
			end
			prev_n = 1'b1;
		end else begin
			prev_n = 1'b0;
			run_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_q      <= '0;
			prev_active_q <= 1'b0;
			run_q         <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (s2_go) begin
				warmup_q      <= warmup_n;
				prev_active_q <= prev_n;
				run_q         <= run_n;
			end
			if (res_free) begin
				res_valid_q <= s2_go;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			res_q.hand_found       <= !warm && (run_n > FOUND_RUN);
			res_q.region_active    <= active;
			res_q.run_length       <= run_n;
			res_q.warming_up       <= warm;
			res_q.foreground_count <= count_s2;
		end
	end

endmodule

### rtl/rfpd_checker.sv
// Port-level checker for the region-of-interest foreground presence detector,
// bound to roi_foreground_presence_detector_top. Depends on rfpd_pkg.
module rfpd_port_checker
	import rfpd_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_ready,
	input res_t                res
);

	// Presence follows the run length, and never during warm-up.
	a_found_rule: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.hand_found == (!res.warming_up && res.run_length > FOUND_RUN)))
		else $error("hand_found disagrees with run_length and warming_up");

	// An active region needs at least one counted pixel.
	a_active_count: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.region_active) |-> (res.foreground_count != '0))
		else $error("region_active with an empty count");

	// After warm-up an inactive frame clears the run.
	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.warming_up && !res.region_active) |-> (res.run_length == '0))
		else $error("run_length not cleared by an inactive frame");

	// A stalled result transaction holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
		else $error("stalled result changed");

endmodule

bind roi_foreground_presence_detector_top rfpd_port_checker u_rfpd_port_checker (.*);
